// File: rtl/salagc_pkg.sv
package salagc_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 24;
    localparam int HOLD_W    = 16;

    localparam int DEFAULT_NOISE_HOLD = 480;

    localparam logic [CFG_IDX_W-1:0] REG_RMS_POLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_TARGET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_CEILING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_FLOOR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_POLE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_POLE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LEVEL  = 3'd7;

    localparam logic [23:0] RST_RMS_POLE     = 24'd16777085;
    localparam logic [22:0] RST_NOISE_FLOOR  = 23'd26527;
    localparam logic [22:0] RST_LEVEL_TARGET = 23'd1329491;
    localparam logic [23:0] RST_GAIN_CEILING = 24'd16697825;
    localparam logic [23:0] RST_GAIN_FLOOR   = 24'd1053562;
    localparam logic [23:0] RST_GAIN_POLE    = 24'd16776692;
    localparam logic [23:0] RST_RELEASE_POLE = 24'd16766734;
    localparam logic [23:0] RST_LIMIT_LEVEL  = 24'd8388608;

    localparam logic [23:0] UNITY_GAIN = 24'd4194304;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_left;
        logic signed [SAMPLE_W-1:0] in_right;
        logic signed [SAMPLE_W-1:0] side_left;
        logic signed [SAMPLE_W-1:0] side_right;
    } smp_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
    } res_beat_t;

endpackage

// File: rtl/stereo_auto_level_agc_unit.sv
// Stereo automatic level control with peak limiter. One sample beat is taken
// while idle; smp_stall is high until the result enters the output register
// (which waits while an earlier result is held). A beat runs up to two 46-step
// divisions, a 25-step square root and its multiplies, all on one shared 26x26
// multiplier, a bit-serial square root and a bit-serial divider under one
// sequencer. The result is held there until taken; a new beat is accepted
// as soon as the sequencer is idle. Config writes are only legal while idle.
module stereo_auto_level_agc_unit #(
    parameter int NOISE_HOLD_SAMPLES = salagc_pkg::DEFAULT_NOISE_HOLD
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                smp_valid,
    output logic                                smp_stall,
    input  salagc_pkg::smp_beat_t               smp_data,
    output logic                                res_valid,
    input  logic                                res_stall,
    output salagc_pkg::res_beat_t               res_data,
    input  logic                                cfg_we,
    input  logic [salagc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [salagc_pkg::CFG_W-1:0]        cfg_data
);
    import salagc_pkg::*;

    localparam logic [HOLD_W-1:0] HOLD = HOLD_W'(NOISE_HOLD_SAMPLES);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SQL   = 5'd1;
    localparam logic [4:0] S_SQR   = 5'd2;
    localparam logic [4:0] S_BLEND = 5'd3;
    localparam logic [4:0] S_SQRT  = 5'd4;
    localparam logic [4:0] S_GATE  = 5'd5;
    localparam logic [4:0] S_DIV   = 5'd6;
    localparam logic [4:0] S_CLIP  = 5'd7;
    localparam logic [4:0] S_ENVL  = 5'd8;
    localparam logic [4:0] S_ENVR  = 5'd9;
    localparam logic [4:0] S_SCALE = 5'd10;
    localparam logic [4:0] S_LIMIT = 5'd11;
    localparam logic [4:0] S_TOTAL = 5'd12;
    localparam logic [4:0] S_OUTL  = 5'd13;
    localparam logic [4:0] S_OUTR  = 5'd14;

    localparam logic [1:0] BL_PL   = 2'd0;
    localparam logic [1:0] BL_PR   = 2'd1;
    localparam logic [1:0] BL_GAIN = 2'd2;

    localparam logic DV_TGT  = 1'b0;
    localparam logic DV_FAST = 1'b1;

    localparam logic [5:0] SQRT_LAST = 6'd24;
    localparam logic [5:0] DIV_LAST  = 6'd45;

    logic [23:0] rms_pole_reg, gain_ceiling_reg, gain_floor_reg, gain_pole_reg;
    logic [23:0] release_pole_reg, limit_level_reg;
    logic [22:0] noise_floor_reg, level_target_reg;

    logic [4:0]  state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [1:0]  bsel_reg, bsel_next;
    logic        dsel_reg, dsel_next;

    smp_beat_t   beat_reg, beat_next;
    logic [46:0] sql_reg, sql_next, sqr_reg, sqr_next;
    logic [47:0] pl_reg, pl_next, pr_reg, pr_next;
    logic [HOLD_W-1:0] qc_reg, qc_next;
    logic [23:0] sg_reg, sg_next, el_reg, el_next, er_reg, er_next;
    logic [73:0] acc_reg, acc_next;
    logic [49:0] rad_reg, rad_next;
    logic [25:0] srem_reg, srem_next;
    logic [24:0] rms_reg, rms_next;
    logic [45:0] dq_reg, dq_next;
    logic [24:0] drem_reg, drem_next, dden_reg, dden_next;
    logic [23:0] tgt_reg, tgt_next;
    logic [24:0] scaled_reg, scaled_next;
    logic [22:0] fast_reg, fast_next;
    logic [24:0] total_reg, total_next;
    logic [23:0] ol_reg, ol_next;
    res_beat_t   res_data_reg, res_data_next;
    logic        res_valid_reg, res_valid_next;

    logic signed [25:0] ma, mb;
    logic signed [51:0] prod;

    logic [23:0] bl_p;
    logic [24:0] bl_c;
    logic [47:0] bl_a, bl_b;
    logic [73:0] bl_add, bl_sum;
    logic [47:0] bl_res;
    logic [48:0] psum;

    logic [27:0] sq_rs, sq_t;
    logic [25:0] dv_rs;
    logic        dv_ge;
    logic [45:0] dq_step;
    logic [23:0] abs_l, abs_r, env_max;
    logic [45:0] t1;
    logic        quiet;

    function automatic logic [23:0] abs24(input logic signed [23:0] x);
        abs24 = x[23] ? 24'(-x) : 24'(x);
    endfunction

    function automatic logic [23:0] sat24(input logic signed [51:0] p);
        logic signed [29:0] q;
        q = p[51:22];
        if (q > 30'sd8388607)
            sat24 = 24'h7FFFFF;
        else if (q < -30'sd8388608)
            sat24 = 24'h800000;
        else
            sat24 = q[23:0];
    endfunction

    assign prod = ma * mb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rms_pole_reg     <= RST_RMS_POLE;
            noise_floor_reg  <= RST_NOISE_FLOOR;
            level_target_reg <= RST_LEVEL_TARGET;
            gain_ceiling_reg <= RST_GAIN_CEILING;
            gain_floor_reg   <= RST_GAIN_FLOOR;
            gain_pole_reg    <= RST_GAIN_POLE;
            release_pole_reg <= RST_RELEASE_POLE;
            limit_level_reg  <= RST_LIMIT_LEVEL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RMS_POLE:     rms_pole_reg     <= cfg_data;
                REG_NOISE_FLOOR:  noise_floor_reg  <= cfg_data[22:0];
                REG_LEVEL_TARGET: level_target_reg <= cfg_data[22:0];
                REG_GAIN_CEILING: gain_ceiling_reg <= cfg_data;
                REG_GAIN_FLOOR:   gain_floor_reg   <= cfg_data;
                REG_GAIN_POLE:    gain_pole_reg    <= cfg_data;
                REG_RELEASE_POLE: release_pole_reg <= cfg_data;
                REG_LIMIT_LEVEL:  limit_level_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (bsel_reg)
            BL_PL:
            begin
                bl_p = rms_pole_reg;
                bl_a = pl_reg;
                bl_b = {1'b0, sql_reg};
            end
            BL_PR:
            begin
                bl_p = rms_pole_reg;
                bl_a = pr_reg;
                bl_b = {1'b0, sqr_reg};
            end
            default:
            begin
                bl_p = gain_pole_reg;
                bl_a = {24'd0, sg_reg};
                bl_b = {24'd0, tgt_reg};
            end
        endcase
    end

    assign bl_c    = {1'b1, 24'd0} - {1'b0, bl_p};
    assign abs_l   = abs24(beat_reg.in_left);
    assign abs_r   = abs24(beat_reg.in_right);
    assign env_max = (el_reg > er_reg) ? el_reg : er_reg;

    assign sq_rs = {srem_reg, rad_reg[49:48]};
    assign sq_t  = {1'b0, rms_reg, 2'b01};

    assign dv_rs   = {drem_reg, dq_reg[45]};
    assign dv_ge   = dv_rs >= {1'b0, dden_reg};
    assign dq_step = {dq_reg[44:0], dv_ge};

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            S_SQL:
            begin
                ma = {{2{beat_reg.side_left[23]}}, beat_reg.side_left};
                mb = ma;
            end
            S_SQR:
            begin
                ma = {{2{beat_reg.side_right[23]}}, beat_reg.side_right};
                mb = ma;
            end
            S_BLEND:
            begin
                case (cnt_reg[1:0])
                    2'd0:
                    begin
                        ma = {2'b0, bl_p};
                        mb = {2'b0, bl_a[47:24]};
                    end
                    2'd1:
                    begin
                        ma = {2'b0, bl_p};
                        mb = {2'b0, bl_a[23:0]};
                    end
                    2'd2:
                    begin
                        ma = {1'b0, bl_c};
                        mb = {2'b0, bl_b[47:24]};
                    end
                    default:
                    begin
                        ma = {1'b0, bl_c};
                        mb = {2'b0, bl_b[23:0]};
                    end
                endcase
            end
            S_ENVL:
            begin
                ma = {2'b0, release_pole_reg};
                mb = {2'b0, el_reg};
            end
            S_ENVR:
            begin
                ma = {2'b0, release_pole_reg};
                mb = {2'b0, er_reg};
            end
            S_SCALE:
            begin
                ma = {2'b0, env_max};
                mb = {2'b0, sg_reg};
            end
            S_TOTAL:
            begin
                ma = {2'b0, sg_reg};
                mb = {3'b0, fast_reg};
            end
            S_OUTL:
            begin
                ma = {{2{beat_reg.in_left[23]}}, beat_reg.in_left};
                mb = {1'b0, total_reg};
            end
            S_OUTR:
            begin
                ma = {{2{beat_reg.in_right[23]}}, beat_reg.in_right};
                mb = {1'b0, total_reg};
            end
            default: ;
        endcase
    end

    assign bl_add = cnt_reg[0] ? 74'(prod[49:0]) : (74'(prod[49:0]) << 24);
    assign bl_sum = ((cnt_reg[1:0] == 2'd0) ? 74'd0 : acc_reg) + bl_add;
    assign bl_res = bl_sum[71:24];
    assign psum   = {1'b0, pl_reg} + {1'b0, bl_res};
    assign quiet  = {2'b0, noise_floor_reg} > rms_reg;
    assign t1     = (dq_reg < {22'd0, gain_floor_reg}) ? {22'd0, gain_floor_reg} : dq_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        bsel_next      = bsel_reg;
        dsel_next      = dsel_reg;
        beat_next      = beat_reg;
        sql_next       = sql_reg;
        sqr_next       = sqr_reg;
        pl_next        = pl_reg;
        pr_next        = pr_reg;
        qc_next        = qc_reg;
        sg_next        = sg_reg;
        el_next        = el_reg;
        er_next        = er_reg;
        acc_next       = acc_reg;
        rad_next       = rad_reg;
        srem_next      = srem_reg;
        rms_next       = rms_reg;
        dq_next        = dq_reg;
        drem_next      = drem_reg;
        dden_next      = dden_reg;
        tgt_next       = tgt_reg;
        scaled_next    = scaled_reg;
        fast_next      = fast_reg;
        total_next     = total_reg;
        ol_next        = ol_reg;
        res_data_next  = res_data_reg;
        res_valid_next = res_valid_reg && res_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (smp_valid)
                begin
                    beat_next  = smp_data;
                    state_next = S_SQL;
                end
            end
            S_SQL:
            begin
                sql_next   = prod[46:0];
                state_next = S_SQR;
            end
            S_SQR:
            begin
                sqr_next   = prod[46:0];
                bsel_next  = BL_PL;
                cnt_next   = '0;
                state_next = S_BLEND;
            end
            S_BLEND:
            begin
                acc_next = bl_sum;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    cnt_next = '0;
                    case (bsel_reg)
                        BL_PL:
                        begin
                            pl_next   = bl_res;
                            bsel_next = BL_PR;
                        end
                        BL_PR:
                        begin
                            pr_next    = bl_res;
                            rad_next   = {1'b0, psum};
                            srem_next  = '0;
                            rms_next   = '0;
                            state_next = S_SQRT;
                        end
                        default:
                        begin
                            sg_next    = bl_res[23:0];
                            state_next = S_ENVL;
                        end
                    endcase
                end
            end
            S_SQRT:
            begin
                rad_next = {rad_reg[47:0], 2'b00};
                if (sq_rs >= sq_t)
                begin
                    srem_next = 26'(sq_rs - sq_t);
                    rms_next  = {rms_reg[23:0], 1'b1};
                end
                else
                begin
                    srem_next = sq_rs[25:0];
                    rms_next  = {rms_reg[23:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == SQRT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_GATE;
                end
            end
            S_GATE:
            begin
                if (quiet)
                    qc_next = (qc_reg < HOLD) ? qc_reg + 1'b1 : qc_reg;
                else
                    qc_next = '0;
                if (qc_next >= HOLD)
                begin
                    dq_next    = {22'd0, UNITY_GAIN};
                    state_next = S_CLIP;
                end
                else
                begin
                    dq_next    = {1'b0, level_target_reg, 22'd0};
                    dden_next  = rms_reg + 25'd1;
                    drem_next  = '0;
                    dsel_next  = DV_TGT;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                dq_next   = dq_step;
                drem_next = dv_ge ? 25'(dv_rs - {1'b0, dden_reg}) : dv_rs[24:0];
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next = '0;
                    if (dsel_reg == DV_TGT)
                        state_next = S_CLIP;
                    else
                    begin
                        fast_next  = dq_step[22:0];
                        state_next = S_TOTAL;
                    end
                end
            end
            S_CLIP:
            begin
                tgt_next   = (t1 > {22'd0, gain_ceiling_reg}) ? gain_ceiling_reg : t1[23:0];
                bsel_next  = BL_GAIN;
                cnt_next   = '0;
                state_next = S_BLEND;
            end
            S_ENVL:
            begin
                el_next    = (abs_l > el_reg) ? abs_l : prod[47:24];
                state_next = S_ENVR;
            end
            S_ENVR:
            begin
                er_next    = (abs_r > er_reg) ? abs_r : prod[47:24];
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                scaled_next = prod[46:22];
                state_next  = S_LIMIT;
            end
            S_LIMIT:
            begin
                if (scaled_reg > {1'b0, limit_level_reg})
                begin
                    dq_next    = {limit_level_reg, 22'd0};
                    dden_next  = scaled_reg;
                    drem_next  = '0;
                    dsel_next  = DV_FAST;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    fast_next  = UNITY_GAIN[22:0];
                    state_next = S_TOTAL;
                end
            end
            S_TOTAL:
            begin
                total_next = prod[46:22];
                state_next = S_OUTL;
            end
            S_OUTL:
            begin
                ol_next    = sat24(prod);
                state_next = S_OUTR;
            end
            S_OUTR:
            begin
                if (!(res_valid_reg && res_stall))
                begin
                    res_data_next.out_left  = ol_reg;
                    res_data_next.out_right = sat24(prod);
                    res_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            bsel_reg      <= BL_PL;
            dsel_reg      <= DV_TGT;
            pl_reg        <= '0;
            pr_reg        <= '0;
            qc_reg        <= '0;
            sg_reg        <= UNITY_GAIN;
            el_reg        <= '0;
            er_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            bsel_reg      <= bsel_next;
            dsel_reg      <= dsel_next;
            pl_reg        <= pl_next;
            pr_reg        <= pr_next;
            qc_reg        <= qc_next;
            sg_reg        <= sg_next;
            el_reg        <= el_next;
            er_reg        <= er_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg     <= beat_next;
        sql_reg      <= sql_next;
        sqr_reg      <= sqr_next;
        acc_reg      <= acc_next;
        rad_reg      <= rad_next;
        srem_reg     <= srem_next;
        rms_reg      <= rms_next;
        dq_reg       <= dq_next;
        drem_reg     <= drem_next;
        dden_reg     <= dden_next;
        tgt_reg      <= tgt_next;
        scaled_reg   <= scaled_next;
        fast_reg     <= fast_next;
        total_reg    <= total_next;
        ol_reg       <= ol_next;
        res_data_reg <= res_data_next;
    end

    assign smp_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && !smp_stall |=> smp_stall)
        else $error("sequencer not busy after accepted beat");

    a_result_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg) == S_OUTR)
        else $error("result raised outside final step");

    a_quiet_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        qc_reg <= HOLD)
        else $error("quiet count beyond hold");

    a_sqrt_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SQRT |-> cnt_reg <= SQRT_LAST)
        else $error("square root step count overrun");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> cnt_reg <= DIV_LAST)
        else $error("divider step count overrun");

endmodule
